>>> design/thtemp_pkg.sv
// shared types, constants and ln table generator for the thermistor converter
// no dependencies
`timescale 1ns / 1ps

package thtemp_pkg;

    // fixed-point widths
    localparam int LN_W   = 22;   // ln(ratio), signed q5.16
    localparam int LM_W   = 38;   // ln * 29815
    localparam int B100_W = 23;   // beta * 100
    localparam int DEN_W  = 41;   // signed denominator
    localparam int DM_W   = 40;   // denominator magnitude
    localparam int BN_W   = 31;   // beta * 29815
    localparam int Q_W    = 63;   // quotient of (beta * 29815) << 32
    localparam int TK_W   = 42;   // absolute temperature, signed q.16
    localparam int CQ_W   = 43;   // celsius, signed q.16
    localparam int V_W    = 50;   // scaled celsius, signed q.16

    localparam logic [LM_W-1:0] T0_NUM     = 38'd29815;
    localparam logic [CQ_W-1:0] ZERO_C_Q16 = 43'd17901158;
    localparam logic [63:0]     LN2_Q26    = 64'd46516320;

    // configuration register indexes
    localparam logic [1:0] CFG_BETA  = 2'd0;
    localparam logic [1:0] CFG_SCALE = 2'd1;

    // scale modes
    localparam logic [3:0] SCALE_TENTHS     = 4'd1;
    localparam logic [3:0] SCALE_HUNDREDTHS = 4'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SATURATED = 2'd1;
    localparam logic [1:0] ST_BETA_ZERO = 2'd2;

    // per-item flags that travel with the data
    typedef struct packed {
        logic full_scale;
        logic den_zero;
        logic neg;
    } t_flags;

    // log2 in q32, by repeated squaring of a q30 mantissa
    function automatic logic [63:0] log2_q32(input logic [31:0] n);
        int k;
        logic [63:0] m;
        logic [63:0] frac;
        k = 0;
        frac = '0;
        for (int j = 1; j < 32; j++) begin
            if ((n >> j) != 0) k = j;
        end
        m = 64'(n) << (30 - k);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        if (n == 0) return '0;
        return (64'(k) << 32) | frac;
    endfunction

    // ln((full - x) / x) in signed q5.16, zero sample taken as ratio full
    function automatic logic signed [LN_W-1:0] ln_entry(input int x, input int sb);
        logic [31:0] full;
        logic [31:0] num;
        logic [31:0] den;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] l;
        full = (32'd1 << sb) - 32'd1;
        num  = (x == 0) ? full : full - 32'(x);
        den  = (x == 0) ? 32'd1 : 32'(x);
        if (32'(x) == full) return '0;
        a = log2_q32(num);
        b = log2_q32(den);
        mag = (a < b) ? b - a : a - b;
        l = (mag * LN2_Q26 + (64'd1 << 41)) >> 42;
        return (a < b) ? -LN_W'(l) : LN_W'(l);
    endfunction

endpackage

>>> design/thtemp_ln_rom.sv
// ln ratio table with registered read, one entry per converter code
// depends on thtemp_pkg
`timescale 1ns / 1ps

module thtemp_ln_rom #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [SAMPLE_BITS-1:0]              i_addr,
    output logic signed [thtemp_pkg::LN_W-1:0]  o_data
);
    import thtemp_pkg::*;

    localparam int DEPTH = 1 << SAMPLE_BITS;

    logic signed [LN_W-1:0] w_rom [DEPTH];
    logic signed [LN_W-1:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam logic signed [LN_W-1:0] ENTRY = ln_entry(g, SAMPLE_BITS);
        assign w_rom[g] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

>>> design/thtemp_div.sv
// pipelined restoring divider, one quotient bit per stage
// numerator is (b << 32); depends on thtemp_pkg
`timescale 1ns / 1ps

module thtemp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [thtemp_pkg::BN_W-1:0]   i_b,
    input  logic [thtemp_pkg::DM_W-1:0]   i_dm,
    input  thtemp_pkg::t_flags            i_flags,
    output logic                          o_valid,
    output logic [thtemp_pkg::Q_W-1:0]    o_q,
    output logic [thtemp_pkg::DM_W-1:0]   o_rem,
    output logic [thtemp_pkg::DM_W-1:0]   o_dm,
    output thtemp_pkg::t_flags            o_flags
);
    import thtemp_pkg::*;

    localparam int NS = Q_W;

    logic              r_v  [NS];
    logic [DM_W-1:0]   r_r  [NS];
    logic [Q_W-1:0]    r_q  [NS];
    logic [BN_W-1:0]   r_b  [NS];
    logic [DM_W-1:0]   r_dm [NS];
    t_flags            r_fl [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic            w_vi;
        logic [DM_W-1:0] w_ri;
        logic [Q_W-1:0]  w_qi;
        logic [BN_W-1:0] w_bi;
        logic [DM_W-1:0] w_di;
        t_flags          w_fi;
        logic            w_bit;
        logic [DM_W:0]   w_sh;
        logic            w_ge;

        if (s == 0) begin : g_first
            assign w_vi = i_valid;
            assign w_ri = '0;
            assign w_qi = '0;
            assign w_bi = i_b;
            assign w_di = i_dm;
            assign w_fi = i_flags;
        end else begin : g_next
            assign w_vi = r_v[s-1];
            assign w_ri = r_r[s-1];
            assign w_qi = r_q[s-1];
            assign w_bi = r_b[s-1];
            assign w_di = r_dm[s-1];
            assign w_fi = r_fl[s-1];
        end

        // numerator bits below the beta product are zero
        if (s < BN_W) begin : g_nb
            assign w_bit = w_bi[BN_W-1-s];
        end else begin : g_zb
            assign w_bit = 1'b0;
        end

        assign w_sh = {w_ri, w_bit};
        assign w_ge = (w_sh >= {1'b0, w_di});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s]  <= w_ge ? DM_W'(w_sh - {1'b0, w_di}) : w_sh[DM_W-1:0];
                r_q[s]  <= {w_qi[Q_W-2:0], w_ge};
                r_b[s]  <= w_bi;
                r_dm[s] <= w_di;
                r_fl[s] <= w_fi;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_rem   = r_r[NS-1];
    assign o_dm    = r_dm[NS-1];
    assign o_flags = r_fl[NS-1];

endmodule

>>> design/thermistor_adc_to_temperature.sv
// ntc thermistor sample to celsius converter, beta equation in fixed point
// depends on thtemp_pkg, thtemp_ln_rom, thtemp_div
`timescale 1ns / 1ps

// usage
//   slave stream carries one converter sample per beat in tdata (low SAMPLE_BITS
//   bits used); master stream returns one beat per sample with the temperature
//   in celsius times 1, 10 or 100 and a status code
//   config channel writes beta (index 0) and scale mode (index 1); it is always
//   ready and must only be used while no sample is in flight
// pipeline and throughput
//   ln table read, products, denominator, the 63-stage bit-per-stage divider for the
//   beta equation, round, scale and output; one sample per cycle sustained unless stalled
// reset
//   synchronous active low; all stage valid bits clear, beta returns to 3950 and
//   scale mode to whole degrees
// stalls
//   while a result waits in the output register and the receiver holds tready
//   low, the whole pipeline freezes and tready on the slave side drops; nothing
//   is lost or repeated
module thermistor_adc_to_temperature #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  i_s_tdata,   // [SAMPLE_BITS-1:0] adc_sample
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [23:0]                       o_m_tdata,   // [15:0] temperature, [17:16] status
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_addr,
    input  logic [15:0]                       i_cfg_data
);
    import thtemp_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] FULL = '1;

    // config registers
    logic [15:0] r_beta;
    logic [3:0]  r_scale_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta       <= 16'd3950;
            r_scale_mode <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_BETA:  r_beta       <= i_cfg_data;
                CFG_SCALE: r_scale_mode <= i_cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    // whole pipeline advances unless a result is held at the output
    logic r_ovalid;
    logic w_adv;
    assign w_adv      = !r_ovalid || i_m_tready;
    assign o_s_tready = w_adv;

    logic [SAMPLE_BITS-1:0] w_x;
    assign w_x = i_s_tdata[SAMPLE_BITS-1:0];

    // stage 1: ln table read
    logic signed [LN_W-1:0] w_l;
    logic                   r_v1;
    logic                   r_full1;

    thtemp_ln_rom #(.SAMPLE_BITS(SAMPLE_BITS)) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_addr (w_x),
        .o_data (w_l)
    );

    // stage 2: products
    logic                   r_v2;
    logic                   r_full2;
    logic signed [LM_W-1:0] r_lm;
    logic [B100_W-1:0]      r_b100;
    logic [BN_W-1:0]        r_bn2;

    // stage 3: denominator magnitude and sign
    logic                    r_v3;
    t_flags                  r_fl3;
    logic [DM_W-1:0]         r_dm3;
    logic [BN_W-1:0]         r_bn3;
    logic signed [DEN_W-1:0] w_den;

    assign w_den = DEN_W'(r_lm) + DEN_W'($signed({1'b0, r_b100, 16'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_full1 <= (w_x == FULL);
            r_full2 <= r_full1;
            r_lm    <= LM_W'(w_l) * $signed(T0_NUM);
            r_b100  <= B100_W'(r_beta * 23'd100);
            r_bn2   <= BN_W'(r_beta * 31'd29815);
            r_fl3.full_scale <= r_full2;
            r_fl3.den_zero   <= (w_den == '0);
            r_fl3.neg        <= w_den[DEN_W-1];
            r_dm3 <= w_den[DEN_W-1] ? DM_W'(-w_den) : DM_W'(w_den);
            r_bn3 <= r_bn2;
        end
    end

    // divider stages
    logic            w_dv;
    logic [Q_W-1:0]  w_q;
    logic [DM_W-1:0] w_rem;
    logic [DM_W-1:0] w_ddm;
    t_flags          w_dfl;

    thtemp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v3),
        .i_b     (r_bn3),
        .i_dm    (r_dm3),
        .i_flags (r_fl3),
        .o_valid (w_dv),
        .o_q     (w_q),
        .o_rem   (w_rem),
        .o_dm    (w_ddm),
        .o_flags (w_dfl)
    );

    // round stage: half-up quotient, clamp to 2^40, apply sign
    logic [Q_W:0]           w_qr;
    logic [TK_W-2:0]        w_mag;
    logic                   r_vr;
    logic                   r_dzr;
    logic signed [TK_W-1:0] r_tk;

    assign w_qr  = {1'b0, w_q} + (Q_W+1)'({w_rem, 1'b0} >= {1'b0, w_ddm});
    assign w_mag = (w_qr > (Q_W+1)'(64'd1 << 40)) ? (TK_W-1)'(64'd1 << 40)
                                                  : w_qr[TK_W-2:0];

    // scale stage
    logic [6:0]             w_scale;
    logic signed [CQ_W-1:0] w_cq;
    logic                   r_vm;
    logic                   r_dzm;
    logic signed [V_W-1:0]  r_v;

    always_comb begin
        case (r_scale_mode)
            SCALE_TENTHS:     w_scale = 7'd10;
            SCALE_HUNDREDTHS: w_scale = 7'd100;
            default:          w_scale = 7'd1;
        endcase
    end

    assign w_cq = CQ_W'(r_tk) - $signed(ZERO_C_Q16);

    // output stage: round half away from zero, saturate to int16, flag a zero beta
    logic [V_W-1:0]  w_vmag;
    logic [V_W-16:0] w_rm;
    logic            w_vneg;
    logic [15:0]     w_temp;
    logic [1:0]      w_status;
    logic [15:0]     r_temp;
    logic [1:0]      r_status;

    assign w_vneg = r_v[V_W-1];
    assign w_vmag = w_vneg ? V_W'(-r_v) : V_W'(r_v);
    assign w_rm   = (V_W-15)'((w_vmag + V_W'(32768)) >> 16);

    always_comb begin
        w_temp   = '0;
        w_status = ST_OK;
        if (r_beta == '0) begin
            w_status = ST_BETA_ZERO;
        end else if (r_dzm) begin
            w_temp   = 16'h7fff;
            w_status = ST_SATURATED;
        end else if (!w_vneg && w_rm > (V_W-15)'(32767)) begin
            w_temp   = 16'h7fff;
            w_status = ST_SATURATED;
        end else if (w_vneg && w_rm > (V_W-15)'(32768)) begin
            w_temp   = 16'h8000;
            w_status = ST_SATURATED;
        end else begin
            w_temp = w_vneg ? -w_rm[15:0] : w_rm[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr     <= 1'b0;
            r_vm     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_vr     <= w_dv;
            r_vm     <= r_vr;
            r_ovalid <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // full-scale sample means zero kelvin
            if (w_dfl.full_scale) begin
                r_tk <= '0;
            end else begin
                r_tk <= w_dfl.neg ? -TK_W'({1'b0, w_mag}) : TK_W'({1'b0, w_mag});
            end
            r_dzr    <= w_dfl.den_zero && !w_dfl.full_scale;
            r_v      <= V_W'(w_cq) * V_W'($signed({1'b0, w_scale}));
            r_dzm    <= r_dzr;
            r_temp   <= w_temp;
            r_status <= w_status;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_status, r_temp};

endmodule

>>> bench/thermistor_adc_to_temperature_checker.sv
// checker for the thermistor converter: predicts each result beat and compares it
// depends on thtemp_pkg for register indexes and status codes
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import thtemp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] temp;
    } t_temp_result;

    logic [15:0]  beta_q;
    logic [3:0]   scale_q;
    t_temp_result temp_expect_q[$];

    function automatic longint unsigned log2_fix(input int unsigned n);
        int k;
        longint unsigned m;
        longint unsigned frac;
        k = 0;
        frac = 0;
        if (n == 0) return 0;
        while (k < 31 && (n >> (k + 1)) != 0) k++;
        m = longint'(n) << (30 - k);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 32) | frac;
    endfunction

    function automatic t_temp_result convert_sample(input logic [11:0] x,
                                                    input logic [15:0] beta,
                                                    input logic [3:0] mode);
        t_temp_result r;
        longint unsigned a, b, mag, num, dm, q, rem, um;
        longint l, den, tk, v, res, scale;
        logic sat_pos;
        r.status = ST_OK;
        sat_pos = 1'b0;
        tk = 0;
        if (beta == 0) begin
            r.status = ST_BETA_ZERO;
            r.temp = '0;
            return r;
        end
        scale = (mode == SCALE_TENTHS) ? 10 : (mode == SCALE_HUNDREDTHS) ? 100 : 1;
        if (x != 12'hfff) begin
            // ratio (4095 - x) / x, zero sample gives 4095 / 1
            a = log2_fix((x == 0) ? 4095 : 4095 - x);
            b = log2_fix((x == 0) ? 1 : x);
            mag = (a < b) ? b - a : a - b;
            l = longint'((mag * 64'd46516320 + (64'd1 << 41)) >> 42);
            if (a < b) l = -l;
            den = l * 29815 + longint'(beta) * 6553600;
            if (den == 0) begin
                sat_pos = 1'b1;
            end else begin
                num = (longint'(beta) * 29815) << 32;
                dm = (den < 0) ? -den : den;
                q = num / dm;
                rem = num % dm;
                if (2 * rem >= dm) q++;
                if (q > (64'd1 << 40)) q = 64'd1 << 40;
                tk = (den < 0) ? -longint'(q) : longint'(q);
            end
        end
        if (sat_pos) begin
            res = 32767;
            r.status = ST_SATURATED;
        end else begin
            // round after scaling, half away from zero
            v = (tk - 17901158) * scale;
            um = (v < 0) ? -v : v;
            um = (um + 32768) >> 16;
            res = (v < 0) ? -longint'(um) : longint'(um);
            if (res > 32767) begin
                res = 32767;
                r.status = ST_SATURATED;
            end else if (res < -32768) begin
                res = -32768;
                r.status = ST_SATURATED;
            end
        end
        r.temp = res[15:0];
        return r;
    endfunction

    assign o_pending = temp_expect_q.size();

    always @(posedge i_clk) begin
        t_temp_result want;
        if (!i_rst_n) begin
            beta_q <= 16'd3950;
            scale_q <= '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_addr == CFG_BETA) beta_q <= i_cfg_data;
                else if (i_cfg_addr == CFG_SCALE) scale_q <= i_cfg_data[3:0];
            end
            if (i_s_tvalid && i_s_tready)
                temp_expect_q.push_back(convert_sample(i_s_tdata[11:0], beta_q, scale_q));
            if (i_m_tvalid && i_m_tready) begin
                if (temp_expect_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = temp_expect_q.pop_front();
                    if (want.temp !== i_m_tdata[15:0] || want.status !== i_m_tdata[17:16]) begin
                        if (o_fail_count < 10)
                            $display("mismatch: temp exp %0d got %0d, status exp %0d got %0d",
                                     $signed(want.temp), $signed(i_m_tdata[15:0]),
                                     want.status, i_m_tdata[17:16]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/thermistor_adc_to_temperature_tb.sv
// testbench top for the thermistor converter: clock, reset, stimulus and verdict
// depends on thtemp_pkg, the converter rtl and thermistor_adc_to_temperature_checker
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_tb;
    import thtemp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 80;    // a margin above the pipeline depth

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          src_idle = 0;   // percent of beats the source holds off
    int          sink_idle = 0;  // percent of cycles the sink stalls

    always #4 i_clk = ~i_clk;

    thermistor_adc_to_temperature u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    thermistor_adc_to_temperature_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // sink stalls at random, one decision per falling edge
    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= sink_idle);

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[thermistor_adc_to_temperature] ERROR");
            $finish;
        end
    end

    // one sample beat; entered and left at a falling edge
    task automatic send_sample(input logic [15:0] word);
        logic rdy;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        forever begin
            #1 rdy = s_tready;
            @(posedge i_clk);
            @(negedge i_clk);
            if (rdy) break;
        end
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
        logic rdy;
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        forever begin
            #1 rdy = cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
            if (rdy) break;
        end
        cfg_valid <= 1'b0;
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_samples(input int count);
        logic [11:0] x;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: x = 12'($urandom_range(15));               // near zero sample
                1: x = 12'hfff - 12'($urandom_range(15));     // near full scale
                default: x = 12'($urandom_range(4095));
            endcase
            send_sample({4'($urandom_range(15)), x});
        end
    endtask

    // beta and scale mode per phase, extremes included
    logic [15:0] beta_tab [9] = '{16'd3950, 16'd0, 16'd65535, 16'd1, 16'd3435,
                                  16'd100, 16'd20000, 16'd0, 16'd4250};
    logic [3:0]  mode_tab [9] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd15, 4'd1, 4'd7, 4'd2, 4'd1};
    logic [11:0] edge_x [12] = '{12'd0, 12'd1, 12'd2, 12'd3, 12'd100, 12'd2047,
                                 12'd2048, 12'd3000, 12'd4093, 12'd4094, 12'd4095,
                                 12'd1365};

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset registers first, ends of the sample range, stray high bits
        foreach (edge_x[i]) send_sample({4'h0, edge_x[i]});
        send_sample(16'hf000);
        send_sample(16'hffff);
        send_sample(16'ha800);
        drain();
        write_reg(CFG_SCALE, 16'hfff2);   // high bits ignored, hundredths
        write_reg(CFG_BETA, 16'd1);       // negative denominator for large samples
        foreach (edge_x[i]) send_sample({4'h5, edge_x[i]});
        drain();

        for (int p = 0; p < 9; p++) begin
            // idle profile: source mostly busy, then sink mostly busy, then none
            src_idle = (p < 3) ? 16 : (p < 6) ? 85 : 0;
            sink_idle = (p < 3) ? 85 : (p < 6) ? 16 : 0;
            write_reg(CFG_BETA, beta_tab[p]);
            write_reg(CFG_SCALE, {12'($urandom), mode_tab[p]});
            random_samples(145);
            drain();
        end

        if (fail_count == 0) begin
            $display("[thermistor_adc_to_temperature] OK");
        end else begin
            $display("[thermistor_adc_to_temperature] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/thtemp_pkg.sv
design/thtemp_ln_rom.sv
design/thtemp_div.sv
design/thermistor_adc_to_temperature.sv
bench/thermistor_adc_to_temperature_checker.sv
bench/thermistor_adc_to_temperature_tb.sv
